### hdl/newton_integer_square_root_defines.svh
// Assertion macros for the integer square root block.
`ifndef NEWTON_INTEGER_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_INTEGER_SQUARE_ROOT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLIES(label, clock, rstn, ante, cons)
`define ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

### hdl/nisr_pkg.sv
// Shared widths, constants and sequencer state type for the integer square root block.
package nisr_pkg;

    localparam int RADICAND_W             = 32;
    localparam int ROOT_W                 = 16;
    localparam int NBITS_W                = $clog2(RADICAND_W + 1);
    localparam int BIT_CNT_W              = $clog2(RADICAND_W);
    localparam int MAX_ITERATIONS_DEFAULT = 5;
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_COUNT  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

endpackage

### hdl/newton_integer_square_root.sv
// Newton-Raphson integer square root with a shared bit-serial divider.
// A radicand is taken when s_tready is high (the sequencer is idle); the root is
// held in an output register, so a new radicand may enter while the previous root
// still waits on m_tready. After acceptance the sequencer counts nbits, the count
// of significant bits of the radicand (bit-serial count, one bit a cycle), then
// runs k Newton steps (1 to MAX_ITERATIONS); each step is a pass of the shared
// restoring divider, one quotient bit per cycle, then an update. The final update
// waits for the previous root to leave the output register before it loads the
// new root and raises m_tvalid.
`include "newton_integer_square_root_defines.svh"

module newton_integer_square_root #(
    parameter int MAX_ITERATIONS = nisr_pkg::MAX_ITERATIONS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nisr_pkg::RADICAND_W-1:0] s_tdata,  // [31:0] radicand
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nisr_pkg::ROOT_W-1:0]     m_tdata   // [15:0] root
);

    import nisr_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    state_t                 state_reg, state_next;
    logic [RADICAND_W-1:0]  radicand_reg, radicand_next;
    logic [RADICAND_W-1:0]  work_reg, work_next;
    logic [RADICAND_W-1:0]  quo_reg, quo_next;
    logic [ROOT_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]      est_reg, est_next;
    logic [NBITS_W-1:0]     nbits_reg, nbits_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [ROOT_W-1:0]      root_reg, root_next;

    logic                   in_xact;
    logic                   out_free;
    logic [NBITS_W-2:0]     seed_shift;
    logic [ROOT_W-1:0]      seed;
    logic [ROOT_W:0]        rem_shift;
    logic                   sub_ok;
    logic [ROOT_W:0]        rem_diff;
    logic [RADICAND_W:0]    step_sum;
    logic [RADICAND_W-1:0]  step_half;
    logic [ROOT_W-1:0]      step_val;
    logic [ROOT_W-1:0]      step_diff;
    logic                   step_stop;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xact  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = root_reg;

    assign seed_shift = nbits_reg[NBITS_W-1:1];
    assign seed       = (seed_shift == (NBITS_W-1)'(ROOT_W)) ? ROOT_MAX
                        : ROOT_W'(1) << seed_shift[$clog2(ROOT_W)-1:0];

    assign rem_shift = {rem_reg, quo_reg[RADICAND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, est_reg};
    assign sub_ok    = (rem_shift >= {1'b0, est_reg});

    assign step_sum  = {1'b0, quo_reg} + (RADICAND_W+1)'(est_reg);
    assign step_half = step_sum[RADICAND_W:1];
    assign step_val  = (|step_half[RADICAND_W-1:ROOT_W]) ? ROOT_MAX
                       : step_half[ROOT_W-1:0];
    assign step_diff = (est_reg > step_val) ? (est_reg - step_val) : (step_val - est_reg);
    assign step_stop = (step_diff <= ROOT_W'(1)) || (step_val == '0)
                       || (iter_reg == ITER_W'(MAX_ITERATIONS - 1));

    always_comb
    begin
        state_next    = state_reg;
        radicand_next = radicand_reg;
        work_next     = work_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        est_next      = est_reg;
        nbits_next    = nbits_reg;
        bit_cnt_next  = bit_cnt_reg;
        iter_next     = iter_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        root_next     = root_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    radicand_next = s_tdata;
                    work_next     = s_tdata;
                    nbits_next    = '0;
                    state_next    = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (work_reg != '0)
                begin
                    work_next  = work_reg >> 1;
                    nbits_next = nbits_reg + NBITS_W'(1);
                end
                else
                begin
                    est_next     = seed;
                    quo_next     = radicand_reg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    iter_next    = '0;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next     = sub_ok ? rem_diff[ROOT_W-1:0] : rem_shift[ROOT_W-1:0];
                quo_next     = {quo_reg[RADICAND_W-2:0], sub_ok};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(RADICAND_W - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (step_stop)
                begin
                    if (out_free)
                    begin
                        root_next     = step_val;
                        m_tvalid_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    est_next     = step_val;
                    quo_next     = radicand_reg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    iter_next    = iter_reg + ITER_W'(1);
                    state_next   = ST_DIVIDE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radicand_reg <= radicand_next;
        work_reg     <= work_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        est_reg      <= est_next;
        nbits_reg    <= nbits_next;
        bit_cnt_reg  <= bit_cnt_next;
        iter_reg     <= iter_next;
        root_reg     <= root_next;
    end

    `ASSERT_NEXT(a_accept_starts_count, clk, rst_n, in_xact, state_reg == ST_COUNT)
    `ASSERT_IMPLIES(a_divisor_nonzero, clk, rst_n, state_reg == ST_DIVIDE, est_reg != '0)
    `ASSERT_IMPLIES(a_remainder_below_divisor, clk, rst_n,
                    state_reg == ST_DIVIDE || state_reg == ST_UPDATE, rem_reg < est_reg)

endmodule
